// ===== hw/rtl/i8svx_pkg.sv =====
// Shared types and constants for the IFF 8SVX chunk parser.
// Holds chunk tags, chunk kind codes, result event codes and the VHDR field layout.
// No dependencies.
`timescale 1ns / 1ps

package i8svx_pkg;

  // Big-endian four-character identifiers.
  localparam logic [31:0] TAG_FORM = 32'h464F524D;
  localparam logic [31:0] TAG_8SVX = 32'h38535658;
  localparam logic [31:0] TAG_VHDR = 32'h56484452;
  localparam logic [31:0] TAG_NAME = 32'h4E414D45;
  localparam logic [31:0] TAG_ANNO = 32'h414E4E4F;
  localparam logic [31:0] TAG_COPY = 32'h434F5059;
  localparam logic [31:0] TAG_AUTH = 32'h41555448;
  localparam logic [31:0] TAG_ATAK = 32'h4154414B;
  localparam logic [31:0] TAG_RLSE = 32'h524C5345;
  localparam logic [31:0] TAG_BODY = 32'h424F4459;
  localparam logic [31:0] TAG_CHAN = 32'h4348414E;

  // Highest octave count that a BODY chunk may use.
  localparam int unsigned MAX_OCTAVES = 10;

  typedef logic [2:0] kind_t;
  localparam kind_t KIND_OTHER = 3'd0;
  localparam kind_t KIND_VHDR  = 3'd1;
  localparam kind_t KIND_TEXT  = 3'd2;
  localparam kind_t KIND_SKIP  = 3'd3;
  localparam kind_t KIND_BODY  = 3'd4;

  typedef logic [2:0] event_t;
  localparam event_t EV_NONE     = 3'd0;
  localparam event_t EV_FIELD    = 3'd1;
  localparam event_t EV_TEXT     = 3'd2;
  localparam event_t EV_SAMPLE   = 3'd3;
  localparam event_t EV_NOT_FORM = 3'd4;
  localparam event_t EV_NOT_8SVX = 3'd5;
  localparam event_t EV_FINISHED = 3'd6;
  localparam event_t EV_TOO_MANY = 3'd7;

  typedef logic [2:0] field_t;
  localparam field_t FIELD_ONESHOT     = 3'd0;
  localparam field_t FIELD_REPEAT      = 3'd1;
  localparam field_t FIELD_PER_CYCLE   = 3'd2;
  localparam field_t FIELD_RATE        = 3'd3;
  localparam field_t FIELD_OCTAVES     = 3'd4;
  localparam field_t FIELD_COMPRESSION = 3'd5;
  localparam field_t FIELD_VOLUME      = 3'd6;
  localparam field_t FIELD_LAST        = FIELD_VOLUME;

  // Sample span counters saturate at all ones of this width.
  localparam int unsigned SPAN_W = 33;
  typedef logic [SPAN_W-1:0] span_t;

  // Byte size of each VHDR field: oneshot, repeat, per-cycle, rate,
  // octaves, compression, volume.
  function automatic logic [2:0] vhdr_size(input field_t f);
    logic [2:0] sz;
    case (f)
      FIELD_RATE:        sz = 3'd2;
      FIELD_OCTAVES:     sz = 3'd1;
      FIELD_COMPRESSION: sz = 3'd1;
      default:           sz = 3'd4;
    endcase
    return sz;
  endfunction

endpackage

// ===== hw/rtl/i8svx_in_if.sv =====
// Input byte channel of the IFF 8SVX chunk parser: valid/ready plus one file byte.
// Standalone interface, no dependencies.
`timescale 1ns / 1ps

interface i8svx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// ===== hw/rtl/i8svx_out_if.sv =====
// Result channel of the IFF 8SVX chunk parser: valid/ready plus one parse event.
// Standalone interface, no dependencies.
`timescale 1ns / 1ps

interface i8svx_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [2:0]  field_id;
  logic [31:0] value;
  logic [3:0]  octave;

  modport source (output valid, output event_res, output field_id, output value,
                  output octave, input ready);
  modport sink   (input valid, input event_res, input field_id, input value,
                  input octave, output ready);
endinterface

// ===== hw/rtl/i8svx_classify.sv =====
// Chunk identifier decoder: maps a four-character tag to a chunk kind.
// Depends on i8svx_pkg.
`timescale 1ns / 1ps

module i8svx_classify (
  input  logic [31:0]     tag,
  output i8svx_pkg::kind_t kind
);

  always_comb begin
    if (tag == i8svx_pkg::TAG_VHDR) begin
      kind = i8svx_pkg::KIND_VHDR;
    end else if (tag == i8svx_pkg::TAG_NAME || tag == i8svx_pkg::TAG_ANNO ||
                 tag == i8svx_pkg::TAG_COPY || tag == i8svx_pkg::TAG_AUTH) begin
      kind = i8svx_pkg::KIND_TEXT;
    end else if (tag == i8svx_pkg::TAG_ATAK || tag == i8svx_pkg::TAG_RLSE ||
                 tag == i8svx_pkg::TAG_CHAN) begin
      kind = i8svx_pkg::KIND_SKIP;
    end else if (tag == i8svx_pkg::TAG_BODY) begin
      kind = i8svx_pkg::KIND_BODY;
    end else begin
      kind = i8svx_pkg::KIND_OTHER;
    end
  end

endmodule

// ===== hw/rtl/iff_8svx_chunk_parser_top.sv =====
// Top level of the IFF 8SVX chunk parser.
// Depends on i8svx_pkg, i8svx_in_if, i8svx_out_if and i8svx_classify.
`timescale 1ns / 1ps

// Usage:
// The in_ch channel carries the sound file one byte per transaction, starting
// with the FORM identifier. The out_ch channel carries parse events: VHDR
// header fields, text bytes, sample bytes with their octave index, and the
// terminal events (not FORM, not 8SVX, too many octaves, finished).
// Each accepted byte yields at most one event. Every byte is decoded in the
// cycle it is accepted and its event sits in the output register from the
// next cycle, so throughput is one byte per cycle while the output register
// is empty or draining. The byte decode, the 33-bit running-total add and
// compare, and the octave span update are all combinational.
// When the receiver stalls, the held event stays in the output register and
// in_ch.ready stays high only while that register is being drained in the
// same cycle; no event is lost or repeated.
// After a terminal event the block keeps accepting and dropping bytes until
// reset. rst_n is synchronous and active low; it returns the parser to
// waiting for FORM and empties the output register.
module iff_8svx_chunk_parser_top (
  input  logic         clk,
  input  logic         rst_n,
  i8svx_in_if.sink     in_ch,
  i8svx_out_if.source  out_ch
);

  localparam logic [3:0] PH_FORM_ID   = 4'd0;
  localparam logic [3:0] PH_FORM_LEN  = 4'd1;
  localparam logic [3:0] PH_FORM_TYPE = 4'd2;
  localparam logic [3:0] PH_CK_ID     = 4'd3;
  localparam logic [3:0] PH_CK_LEN    = 4'd4;
  localparam logic [3:0] PH_VHDR      = 4'd5;
  localparam logic [3:0] PH_TEXT      = 4'd6;
  localparam logic [3:0] PH_SKIP      = 4'd7;
  localparam logic [3:0] PH_BODY      = 4'd8;
  localparam logic [3:0] PH_FIN_PEND  = 4'd9;
  localparam logic [3:0] PH_HALT      = 4'd10;

  logic [3:0]              phase_r, phase_nxt;
  logic [1:0]              byte_pos_r, byte_pos_nxt;
  logic [31:0]             asm_r, asm_nxt;
  i8svx_pkg::kind_t        kind_r, kind_nxt;
  logic [31:0]             remaining_r, remaining_nxt;
  logic [31:0]             form_len_r, form_len_nxt;
  logic [32:0]             run_total_r, run_total_nxt;
  logic [31:0]             oneshot_r, oneshot_nxt;
  logic [31:0]             repeat_r, repeat_nxt;
  logic [7:0]              oct_count_r, oct_count_nxt;
  logic [3:0]              cur_oct_r, cur_oct_nxt;
  i8svx_pkg::span_t        span_left_r, span_left_nxt;
  i8svx_pkg::span_t        span_full_r, span_full_nxt;
  i8svx_pkg::field_t       hfield_r, hfield_nxt;

  logic                    out_valid_r;
  i8svx_pkg::event_t       out_event_r;
  logic [2:0]              out_field_r;
  logic [31:0]             out_value_r;
  logic [3:0]              out_octave_r;

  logic                    emit;
  i8svx_pkg::event_t       emit_event;
  logic [2:0]              emit_field;
  logic [31:0]             emit_value;
  logic [3:0]              emit_octave;

  logic                    accept;
  logic [7:0]              b;
  logic [31:0]             asm_shift;
  logic                    word_done;
  i8svx_pkg::kind_t        id_kind;
  logic [32:0]             len_sum;
  logic                    fin_cur;
  logic                    fin_add;
  i8svx_pkg::span_t        per_octave;
  logic [33:0]             span_grow;
  i8svx_pkg::span_t        span_next_oct;
  logic [2:0]              vhdr_pos_inc;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign b            = in_ch.data_byte;
  assign asm_shift    = {asm_r[23:0], b};
  assign word_done    = (byte_pos_r == 2'd3);
  assign len_sum      = run_total_r + {1'b0, asm_shift};
  assign fin_cur      = (run_total_r >= {1'b0, form_len_r});
  assign fin_add      = (len_sum >= {1'b0, form_len_r});
  assign per_octave   = {1'b0, oneshot_r} + {1'b0, repeat_r};
  // Next octave's span is one more multiple of oneshot+repeat, saturated.
  assign span_grow    = {1'b0, span_full_r} + {1'b0, per_octave};
  assign span_next_oct = span_grow[33] ? '1 : span_grow[32:0];
  assign vhdr_pos_inc = {1'b0, byte_pos_r} + 3'd1;

  i8svx_classify u_classify (
    .tag  (asm_shift),
    .kind (id_kind)
  );

  always_comb begin
    phase_nxt     = phase_r;
    byte_pos_nxt  = byte_pos_r;
    asm_nxt       = asm_r;
    kind_nxt      = kind_r;
    remaining_nxt = remaining_r;
    form_len_nxt  = form_len_r;
    run_total_nxt = run_total_r;
    oneshot_nxt   = oneshot_r;
    repeat_nxt    = repeat_r;
    oct_count_nxt = oct_count_r;
    cur_oct_nxt   = cur_oct_r;
    span_left_nxt = span_left_r;
    span_full_nxt = span_full_r;
    hfield_nxt    = hfield_r;
    emit          = 1'b0;
    emit_event    = i8svx_pkg::EV_NONE;
    emit_field    = 3'd0;
    emit_value    = 32'd0;
    emit_octave   = 4'd0;

    case (phase_r)
      PH_FORM_ID: begin
        asm_nxt      = asm_shift;
        byte_pos_nxt = byte_pos_r + 2'd1;
        if (word_done) begin
          if (asm_shift != i8svx_pkg::TAG_FORM) begin
            phase_nxt  = PH_HALT;
            emit       = 1'b1;
            emit_event = i8svx_pkg::EV_NOT_FORM;
          end else begin
            phase_nxt = PH_FORM_LEN;
          end
        end
      end
      PH_FORM_LEN: begin
        asm_nxt      = asm_shift;
        byte_pos_nxt = byte_pos_r + 2'd1;
        if (word_done) begin
          form_len_nxt = asm_shift;
          phase_nxt    = PH_FORM_TYPE;
        end
      end
      PH_FORM_TYPE: begin
        asm_nxt      = asm_shift;
        byte_pos_nxt = byte_pos_r + 2'd1;
        if (word_done) begin
          if (asm_shift != i8svx_pkg::TAG_8SVX) begin
            phase_nxt  = PH_HALT;
            emit       = 1'b1;
            emit_event = i8svx_pkg::EV_NOT_8SVX;
          end else begin
            run_total_nxt = 33'd0;
            asm_nxt       = 32'd0;
            // An empty form is finished as soon as its type is read.
            if (form_len_r == 32'd0) begin
              phase_nxt  = PH_HALT;
              emit       = 1'b1;
              emit_event = i8svx_pkg::EV_FINISHED;
            end else begin
              phase_nxt = PH_CK_ID;
            end
          end
        end
      end
      PH_CK_ID: begin
        asm_nxt      = asm_shift;
        byte_pos_nxt = byte_pos_r + 2'd1;
        if (word_done) begin
          kind_nxt  = id_kind;
          phase_nxt = PH_CK_LEN;
        end
      end
      PH_CK_LEN: begin
        asm_nxt      = asm_shift;
        byte_pos_nxt = byte_pos_r + 2'd1;
        if (word_done) begin
          remaining_nxt = asm_shift;
          run_total_nxt = len_sum;
          if (kind_r == i8svx_pkg::KIND_VHDR) begin
            hfield_nxt = i8svx_pkg::FIELD_ONESHOT;
            asm_nxt    = 32'd0;
            phase_nxt  = PH_VHDR;
          end else if (kind_r == i8svx_pkg::KIND_BODY) begin
            if (oct_count_r > 8'(i8svx_pkg::MAX_OCTAVES)) begin
              phase_nxt  = PH_HALT;
              emit       = 1'b1;
              emit_event = i8svx_pkg::EV_TOO_MANY;
            end else if (oct_count_r == 8'd0 || per_octave == '0) begin
              asm_nxt = 32'd0;
              if (fin_add) begin
                phase_nxt  = PH_HALT;
                emit       = 1'b1;
                emit_event = i8svx_pkg::EV_FINISHED;
              end else begin
                phase_nxt = PH_CK_ID;
              end
            end else begin
              cur_oct_nxt   = 4'd0;
              span_left_nxt = per_octave;
              span_full_nxt = per_octave;
              phase_nxt     = PH_BODY;
            end
          end else if (asm_shift == 32'd0) begin
            asm_nxt = 32'd0;
            if (fin_add) begin
              phase_nxt  = PH_HALT;
              emit       = 1'b1;
              emit_event = i8svx_pkg::EV_FINISHED;
            end else begin
              phase_nxt = PH_CK_ID;
            end
          end else if (kind_r == i8svx_pkg::KIND_TEXT) begin
            phase_nxt = PH_TEXT;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end
      end
      PH_VHDR: begin
        if (vhdr_pos_inc < i8svx_pkg::vhdr_size(hfield_r)) begin
          asm_nxt      = asm_shift;
          byte_pos_nxt = byte_pos_r + 2'd1;
        end else begin
          if (hfield_r == i8svx_pkg::FIELD_ONESHOT) begin
            oneshot_nxt = asm_shift;
          end else if (hfield_r == i8svx_pkg::FIELD_REPEAT) begin
            repeat_nxt = asm_shift;
          end else if (hfield_r == i8svx_pkg::FIELD_OCTAVES) begin
            oct_count_nxt = asm_shift[7:0];
          end
          emit         = 1'b1;
          emit_event   = i8svx_pkg::EV_FIELD;
          emit_field   = hfield_r;
          emit_value   = asm_shift;
          byte_pos_nxt = 2'd0;
          asm_nxt      = 32'd0;
          if (hfield_r >= i8svx_pkg::FIELD_LAST) begin
            hfield_nxt = i8svx_pkg::FIELD_ONESHOT;
            // This byte already carries a result, so finishing waits a byte.
            phase_nxt  = fin_cur ? PH_FIN_PEND : PH_CK_ID;
          end else begin
            hfield_nxt = hfield_r + 3'd1;
          end
        end
      end
      PH_TEXT: begin
        emit          = 1'b1;
        emit_event    = i8svx_pkg::EV_TEXT;
        emit_value    = {24'd0, b};
        remaining_nxt = remaining_r - 32'd1;
        if (remaining_r == 32'd1) begin
          byte_pos_nxt = 2'd0;
          asm_nxt      = 32'd0;
          phase_nxt    = fin_cur ? PH_FIN_PEND : PH_CK_ID;
        end
      end
      PH_SKIP: begin
        remaining_nxt = remaining_r - 32'd1;
        if (remaining_r == 32'd1) begin
          byte_pos_nxt = 2'd0;
          asm_nxt      = 32'd0;
          if (fin_cur) begin
            phase_nxt  = PH_HALT;
            emit       = 1'b1;
            emit_event = i8svx_pkg::EV_FINISHED;
          end else begin
            phase_nxt = PH_CK_ID;
          end
        end
      end
      PH_BODY: begin
        emit        = 1'b1;
        emit_event  = i8svx_pkg::EV_SAMPLE;
        emit_value  = {24'd0, b};
        emit_octave = cur_oct_r;
        if (span_left_r != '0) begin
          span_left_nxt = span_left_r - i8svx_pkg::span_t'(1);
        end
        if (span_left_r <= i8svx_pkg::span_t'(1)) begin
          if (({4'd0, cur_oct_r} + 8'd1) >= oct_count_r) begin
            cur_oct_nxt  = 4'd0;
            byte_pos_nxt = 2'd0;
            asm_nxt      = 32'd0;
            phase_nxt    = fin_cur ? PH_FIN_PEND : PH_CK_ID;
          end else begin
            cur_oct_nxt   = cur_oct_r + 4'd1;
            span_full_nxt = span_next_oct;
            span_left_nxt = span_next_oct;
          end
        end
      end
      PH_FIN_PEND: begin
        phase_nxt  = PH_HALT;
        emit       = 1'b1;
        emit_event = i8svx_pkg::EV_FINISHED;
      end
      default: begin
        phase_nxt = PH_HALT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FORM_ID;
      byte_pos_r  <= 2'd0;
      asm_r       <= 32'd0;
      kind_r      <= i8svx_pkg::KIND_OTHER;
      remaining_r <= 32'd0;
      form_len_r  <= 32'd0;
      run_total_r <= 33'd0;
      oneshot_r   <= 32'd0;
      repeat_r    <= 32'd0;
      oct_count_r <= 8'd0;
      cur_oct_r   <= 4'd0;
      span_left_r <= '0;
      span_full_r <= '0;
      hfield_r    <= i8svx_pkg::FIELD_ONESHOT;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      byte_pos_r  <= byte_pos_nxt;
      asm_r       <= asm_nxt;
      kind_r      <= kind_nxt;
      remaining_r <= remaining_nxt;
      form_len_r  <= form_len_nxt;
      run_total_r <= run_total_nxt;
      oneshot_r   <= oneshot_nxt;
      repeat_r    <= repeat_nxt;
      oct_count_r <= oct_count_nxt;
      cur_oct_r   <= cur_oct_nxt;
      span_left_r <= span_left_nxt;
      span_full_r <= span_full_nxt;
      hfield_r    <= hfield_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_event_r  <= emit_event;
      out_field_r  <= emit_field;
      out_value_r  <= emit_value;
      out_octave_r <= emit_octave;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.event_res = out_event_r;
  assign out_ch.field_id  = out_field_r;
  assign out_ch.value     = out_value_r;
  assign out_ch.octave    = out_octave_r;

endmodule

// ===== hw/rtl/i8svx_checker.sv =====
// Port-level checker for the IFF 8SVX chunk parser, bound to the top level.
// Depends on i8svx_pkg and on the ports of iff_8svx_chunk_parser_top.
`timescale 1ns / 1ps

module i8svx_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  event_res,
  input logic [2:0]  field_id,
  input logic [31:0] value,
  input logic [3:0]  octave
);

  // A stalled result keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(value))
    else $error("stalled result changed");

  // Only the two result-carrying events use field_id and octave.
  a_side_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (event_res != i8svx_pkg::EV_NONE) &&
                  (event_res == i8svx_pkg::EV_FIELD || field_id == 3'd0) &&
                  (event_res == i8svx_pkg::EV_SAMPLE || octave == 4'd0))
    else $error("bad event code or stray side field");

  // Text and sample events carry a single byte; terminal events carry nothing.
  a_byte_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_res != i8svx_pkg::EV_FIELD |-> value[31:8] == 24'd0)
    else $error("byte event carries wide value");

  // Once a terminal event is taken, the parser has nothing more to say.
  a_halt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && event_res >= i8svx_pkg::EV_NOT_FORM |=> !out_valid)
    else $error("result after terminal event");

  // The output register frees the input side whenever it drains.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while output is free");

endmodule

bind iff_8svx_chunk_parser_top i8svx_checker u_i8svx_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .event_res (out_ch.event_res),
  .field_id  (out_ch.field_id),
  .value     (out_ch.value),
  .octave    (out_ch.octave)
);

// ===== bench/tb_iff_8svx_chunk_parser_top.sv =====
// Testbench for iff_8svx_chunk_parser_top: streams one long 8SVX file and checks every event
// against a byte-level parser model kept in this file.
// Depends on i8svx_pkg, i8svx_in_if, i8svx_out_if and the parser RTL.
`timescale 1ns / 1ps

module tb_iff_8svx_chunk_parser_top;

  localparam int HOLD_CYCLES = 400;

  typedef enum logic [3:0] {
    PH_FORM_ID, PH_FORM_LEN, PH_FORM_TYPE, PH_CK_ID, PH_CK_LEN,
    PH_VHDR, PH_TEXT, PH_SKIP, PH_BODY, PH_FIN_PEND, PH_HALT
  } parse_phase_t;

  typedef struct packed {
    i8svx_pkg::event_t ev;
    i8svx_pkg::field_t fid;
    logic [31:0]       value;
    logic [3:0]        oct;
  } parse_event_t;

  logic clk = 1'b0;
  logic rst_n;

  i8svx_in_if  in_ch ();
  i8svx_out_if out_ch ();

  iff_8svx_chunk_parser_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  // Parser model state.
  parse_phase_t      st_phase    = PH_FORM_ID;
  int                st_pos      = 0;
  logic [31:0]       st_word     = '0;
  i8svx_pkg::kind_t  st_kind     = i8svx_pkg::KIND_OTHER;
  logic [31:0]       st_left     = '0;
  logic [31:0]       st_form_len = '0;
  logic [32:0]       st_total    = '0;
  logic [31:0]       st_oneshot  = '0;
  logic [31:0]       st_repeat   = '0;
  logic [7:0]        st_octaves  = '0;
  logic [3:0]        st_cur_oct  = '0;
  i8svx_pkg::span_t  st_span     = '0;
  i8svx_pkg::field_t st_field    = '0;

  // File image and the header values the generator has put into it.
  logic [7:0]      file_bytes[$];
  longint unsigned gen_total = 0;
  logic [31:0]     gen_os = '0;
  logic [31:0]     gen_rp = '0;
  logic [7:0]      gen_oc = '0;

  parse_event_t expected_events[$];
  int  total_bytes;
  int  bytes_accepted = 0;
  int  events_queued = 0;
  int  events_seen = 0;
  int  mismatch_cnt = 0;
  int  tx_idle_pct = 0;
  int  rx_stall_pct = 0;
  bit  tx_pause = 1'b0;
  bit  hold_go = 1'b0;
  bit  hold_seen = 1'b0;
  int  hold_left = 0;

  function automatic logic [31:0] chunk_tag(input int i);
    case (i)
      0:       return i8svx_pkg::TAG_VHDR;
      1:       return i8svx_pkg::TAG_NAME;
      2:       return i8svx_pkg::TAG_ANNO;
      3:       return i8svx_pkg::TAG_COPY;
      4:       return i8svx_pkg::TAG_AUTH;
      5:       return i8svx_pkg::TAG_ATAK;
      6:       return i8svx_pkg::TAG_RLSE;
      7:       return i8svx_pkg::TAG_CHAN;
      default: return i8svx_pkg::TAG_BODY;
    endcase
  endfunction

  function automatic bit shift_in_byte(input logic [7:0] b);
    st_word = {st_word[23:0], b};
    if (st_pos >= 3) begin
      st_pos = 0;
      return 1'b1;
    end
    st_pos++;
    return 1'b0;
  endfunction

  function automatic i8svx_pkg::span_t span_for(input logic [3:0] k);
    logic [63:0] prod;
    prod = ({32'd0, st_oneshot} + {32'd0, st_repeat}) * ({60'd0, k} + 64'd1);
    if (prod > 64'h1_FFFF_FFFF) return '1;
    return prod[32:0];
  endfunction

  // Returns 1 when the form is complete and the finished event goes out right now.
  // On a step that already produced an event, finished is deferred to the next byte.
  function automatic bit close_chunk(input bit busy);
    st_pos  = 0;
    st_word = '0;
    if (st_total >= {1'b0, st_form_len}) begin
      if (busy) begin
        st_phase = PH_FIN_PEND;
        return 1'b0;
      end
      st_phase = PH_HALT;
      return 1'b1;
    end
    st_phase = PH_CK_ID;
    return 1'b0;
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, output parse_event_t r);
    bit done;
    bit fin;
    int need;
    r    = '0;
    done = 1'b0;
    fin  = 1'b0;
    case (st_phase)
      PH_FORM_ID: begin
        if (shift_in_byte(b)) begin
          if (st_word != i8svx_pkg::TAG_FORM) begin
            st_phase = PH_HALT;
            r.ev = i8svx_pkg::EV_NOT_FORM;
            done = 1'b1;
          end else begin
            st_phase = PH_FORM_LEN;
          end
        end
      end
      PH_FORM_LEN: begin
        if (shift_in_byte(b)) begin
          st_form_len = st_word;
          st_phase = PH_FORM_TYPE;
        end
      end
      PH_FORM_TYPE: begin
        if (shift_in_byte(b)) begin
          if (st_word != i8svx_pkg::TAG_8SVX) begin
            st_phase = PH_HALT;
            r.ev = i8svx_pkg::EV_NOT_8SVX;
            done = 1'b1;
          end else begin
            st_total = '0;
            fin = close_chunk(1'b0);
          end
        end
      end
      PH_CK_ID: begin
        if (shift_in_byte(b)) begin
          if (st_word == i8svx_pkg::TAG_VHDR) begin
            st_kind = i8svx_pkg::KIND_VHDR;
          end else if (st_word == i8svx_pkg::TAG_NAME || st_word == i8svx_pkg::TAG_ANNO ||
                       st_word == i8svx_pkg::TAG_COPY || st_word == i8svx_pkg::TAG_AUTH) begin
            st_kind = i8svx_pkg::KIND_TEXT;
          end else if (st_word == i8svx_pkg::TAG_ATAK || st_word == i8svx_pkg::TAG_RLSE ||
                       st_word == i8svx_pkg::TAG_CHAN) begin
            st_kind = i8svx_pkg::KIND_SKIP;
          end else if (st_word == i8svx_pkg::TAG_BODY) begin
            st_kind = i8svx_pkg::KIND_BODY;
          end else begin
            st_kind = i8svx_pkg::KIND_OTHER;
          end
          st_phase = PH_CK_LEN;
        end
      end
      PH_CK_LEN: begin
        if (shift_in_byte(b)) begin
          st_left  = st_word;
          st_total = st_total + {1'b0, st_word};
          if (st_kind == i8svx_pkg::KIND_VHDR) begin
            st_field = i8svx_pkg::FIELD_ONESHOT;
            st_pos   = 0;
            st_word  = '0;
            st_phase = PH_VHDR;
          end else if (st_kind == i8svx_pkg::KIND_BODY) begin
            if (st_octaves > i8svx_pkg::MAX_OCTAVES) begin
              st_phase = PH_HALT;
              r.ev = i8svx_pkg::EV_TOO_MANY;
              done = 1'b1;
            end else if (st_octaves == 0 ||
                         ({1'b0, st_oneshot} + {1'b0, st_repeat}) == 33'd0) begin
              fin = close_chunk(1'b0);
            end else begin
              st_cur_oct = '0;
              st_span    = span_for(4'd0);
              st_phase   = PH_BODY;
            end
          end else if (st_left == 0) begin
            fin = close_chunk(1'b0);
          end else begin
            st_phase = (st_kind == i8svx_pkg::KIND_TEXT) ? PH_TEXT : PH_SKIP;
          end
        end
      end
      PH_VHDR: begin
        st_word = {st_word[23:0], b};
        if (st_field > i8svx_pkg::FIELD_LAST) st_field = i8svx_pkg::FIELD_LAST;
        case (st_field)
          i8svx_pkg::FIELD_RATE:        need = 2;
          i8svx_pkg::FIELD_OCTAVES,
          i8svx_pkg::FIELD_COMPRESSION: need = 1;
          default:                      need = 4;
        endcase
        if (st_pos + 1 < need) begin
          st_pos++;
        end else begin
          if (st_field == i8svx_pkg::FIELD_ONESHOT) st_oneshot = st_word;
          else if (st_field == i8svx_pkg::FIELD_REPEAT) st_repeat = st_word;
          else if (st_field == i8svx_pkg::FIELD_OCTAVES) st_octaves = st_word[7:0];
          r.ev    = i8svx_pkg::EV_FIELD;
          r.fid   = st_field;
          r.value = st_word;
          done    = 1'b1;
          st_pos  = 0;
          st_word = '0;
          if (st_field >= i8svx_pkg::FIELD_LAST) begin
            st_field = i8svx_pkg::FIELD_ONESHOT;
            fin = close_chunk(1'b1);
          end else begin
            st_field++;
          end
        end
      end
      PH_TEXT: begin
        r.ev    = i8svx_pkg::EV_TEXT;
        r.value = {24'd0, b};
        done    = 1'b1;
        st_left--;
        if (st_left == 0) fin = close_chunk(1'b1);
      end
      PH_SKIP: begin
        st_left--;
        if (st_left == 0) fin = close_chunk(1'b0);
      end
      PH_BODY: begin
        r.ev    = i8svx_pkg::EV_SAMPLE;
        r.value = {24'd0, b};
        r.oct   = st_cur_oct;
        done    = 1'b1;
        if (st_span != '0) st_span--;
        if (st_span == '0) begin
          if ({28'd0, st_cur_oct} + 32'd1 >= {24'd0, st_octaves}) begin
            st_cur_oct = '0;
            fin = close_chunk(1'b1);
          end else begin
            st_cur_oct = st_cur_oct + 4'd1;
            st_span    = span_for(st_cur_oct);
          end
        end
      end
      PH_FIN_PEND: begin
        st_phase = PH_HALT;
        r.ev = i8svx_pkg::EV_FINISHED;
        done = 1'b1;
      end
      default: st_phase = PH_HALT;
    endcase
    if (fin) begin
      r    = '0;
      r.ev = i8svx_pkg::EV_FINISHED;
      done = 1'b1;
    end
    return done;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_cnt < 25) $display("ERROR at %0t ns: %s", $time, what);
    mismatch_cnt++;
  endtask

  task automatic add_word(input logic [31:0] w);
    file_bytes.push_back(w[31:24]);
    file_bytes.push_back(w[23:16]);
    file_bytes.push_back(w[15:8]);
    file_bytes.push_back(w[7:0]);
  endtask

  task automatic add_filler(input longint unsigned n);
    for (longint unsigned i = 0; i < n; i++) file_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_chunk_head(input logic [31:0] id, input logic [31:0] len);
    add_word(id);
    add_word(len);
    gen_total += len;
  endtask

  // The pattern fills per-cycle, rate and compression; volume takes its inverse.
  task automatic add_vhdr(input logic [31:0] len, input logic [31:0] os, input logic [31:0] rp,
                          input logic [7:0] oc, input logic [31:0] pat);
    add_chunk_head(i8svx_pkg::TAG_VHDR, len);
    add_word(os);
    add_word(rp);
    add_word(pat);
    file_bytes.push_back(pat[15:8]);
    file_bytes.push_back(pat[7:0]);
    file_bytes.push_back(oc);
    file_bytes.push_back(pat[7:0]);
    add_word(~pat);
    gen_os = os;
    gen_rp = rp;
    gen_oc = oc;
  endtask

  // BODY size comes from the last VHDR values only, never from the chunk length.
  task automatic add_body(input logic [31:0] len);
    longint unsigned per;
    add_chunk_head(i8svx_pkg::TAG_BODY, len);
    per = longint'(gen_os) + longint'(gen_rp);
    add_filler(per * gen_oc * (gen_oc + 1) / 2);
  endtask

  task automatic run_until(input int n);
    while (bytes_accepted < n && bytes_accepted < total_bytes) @(posedge clk);
  endtask

  // Sender: one transaction offered at a time, held until the parser takes it.
  always @(posedge clk) begin : drive
    parse_event_t ev;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        bytes_accepted <= bytes_accepted + 1;
        if (decode_byte(in_ch.data_byte, ev)) begin
          expected_events.push_back(ev);
          events_queued <= events_queued + 1;
        end
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (file_bytes.size() != 0 && !tx_pause && $urandom_range(0, 99) >= tx_idle_pct) begin
          in_ch.valid     <= 1'b1;
          in_ch.data_byte <= file_bytes.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
    end else if (hold_seen != hold_go) begin
      hold_seen    <= hold_go;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin : check
    parse_event_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_events.size() == 0) begin
        report_mismatch($sformatf("event %0d arrived with none expected", out_ch.event_res));
      end else begin
        want = expected_events.pop_front();
        events_seen <= events_seen + 1;
        if (out_ch.event_res !== want.ev)
          report_mismatch($sformatf("event_res %0d, expected %0d", out_ch.event_res, want.ev));
        if (out_ch.field_id !== want.fid)
          report_mismatch($sformatf("field_id %0d, expected %0d", out_ch.field_id, want.fid));
        if (out_ch.value !== want.value)
          report_mismatch($sformatf("value %h, expected %h", out_ch.value, want.value));
        if (out_ch.octave !== want.oct)
          report_mismatch($sformatf("octave %0d, expected %0d", out_ch.octave, want.oct));
      end
    end
  end

  initial begin
    #10_000_000;
    $display("tb_iff_8svx_chunk_parser_top NOT OK");
    $finish;
  end

  initial begin
    logic [31:0]     form_len;
    logic [31:0]     id;
    longint unsigned gap;
    longint unsigned per;
    int              pick;
    int              len;
    int              mode;

    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'h00;
    out_ch.ready    = 1'b0;
    rst_n           = 1'b0;

    // Form header. The form length stays far above the middle chunks so that only the
    // closing chunks reach it.
    form_len = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : {1'b1, 31'($urandom)};
    add_word(i8svx_pkg::TAG_FORM);
    add_word(form_len);
    add_word(i8svx_pkg::TAG_8SVX);

    // Directed chunks: BODY before any VHDR, zero-length text and skip chunks,
    // a near-miss identifier, BODY with no sample bytes per octave or no octaves,
    // the largest legal octave count, every text and skip tag, and FORM as a chunk.
    add_body(32'd0);
    add_chunk_head(i8svx_pkg::TAG_NAME, 32'd0);
    add_chunk_head(i8svx_pkg::TAG_ATAK, 32'd0);
    add_chunk_head(32'h424F445A, 32'd2);
    add_filler(2);
    add_vhdr(32'd20, 32'd0, 32'd0, 8'd3, 32'hFFFF_FFFF);
    add_body(32'd7);
    // A huge VHDR length brings the running total close to the top of the
    // 32-bit range while leaving room for the random chunks.
    add_vhdr(32'hFFFF_FFFF - gen_total - 32'h0100_0000, 32'd2, 32'd0, 8'd0, 32'h0000_0000);
    gen_total = 0;
    form_len  = 32'hFFFF_FFFF;
    file_bytes[4] = 8'hFF;
    file_bytes[5] = 8'hFF;
    file_bytes[6] = 8'hFF;
    file_bytes[7] = 8'hFF;
    gap = 32'hFFFF_FFFF - 32'h0100_0000;
    gen_total = gap;
    add_body(32'd1);
    add_vhdr(32'd20, 32'd1, 32'd0, 8'(i8svx_pkg::MAX_OCTAVES), 32'h5A5A_A5A5);
    add_body(32'd55);
    add_chunk_head(i8svx_pkg::TAG_ANNO, 32'd3);
    add_filler(3);
    add_chunk_head(i8svx_pkg::TAG_COPY, 32'd1);
    add_filler(1);
    add_chunk_head(i8svx_pkg::TAG_AUTH, 32'd1);
    add_filler(1);
    add_chunk_head(i8svx_pkg::TAG_RLSE, 32'd1);
    add_filler(1);
    add_chunk_head(i8svx_pkg::TAG_CHAN, 32'd2);
    add_filler(2);
    add_chunk_head(i8svx_pkg::TAG_FORM, 32'd4);
    add_filler(4);

    // Random chunks with random content, lengths kept small.
    while (file_bytes.size() < 1300 && gen_total + 2000 < form_len) begin
      pick = $urandom_range(0, 99);
      per  = longint'(gen_os) + longint'(gen_rp);
      if (pick >= 20 && pick < 38 &&
          (gen_oc == 0 || per == 0 || (gen_oc <= i8svx_pkg::MAX_OCTAVES && per <= 8))) begin
        add_body($urandom_range(0, 300));
      end else if (pick < 20) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : 20;
        case ($urandom_range(0, 9))
          0:       add_vhdr(len, $urandom, $urandom, 8'($urandom_range(0, 255)), $urandom);
          1:       add_vhdr(len, $urandom_range(0, 3), $urandom_range(0, 3),
                            8'($urandom_range(i8svx_pkg::MAX_OCTAVES + 1, 255)), $urandom);
          default: add_vhdr(len, $urandom_range(0, 4), $urandom_range(0, 3),
                            8'($urandom_range(0, i8svx_pkg::MAX_OCTAVES)), $urandom);
        endcase
      end else if (pick < 60) begin
        len = $urandom_range(0, 12);
        add_chunk_head(chunk_tag($urandom_range(1, 4)), len);
        add_filler(len);
      end else if (pick < 78) begin
        len = $urandom_range(0, 16);
        add_chunk_head(chunk_tag($urandom_range(5, 7)), len);
        add_filler(len);
      end else begin
        case ($urandom_range(0, 3))
          0:       id = $urandom;
          1:       id = i8svx_pkg::TAG_FORM;
          2:       id = i8svx_pkg::TAG_8SVX;
          default: id = chunk_tag($urandom_range(0, 8)) ^ (32'd1 << $urandom_range(0, 31));
        endcase
        for (int i = 0; i < 9; i++) if (id == chunk_tag(i)) id = i8svx_pkg::TAG_FORM;
        len = $urandom_range(0, 16);
        add_chunk_head(id, len);
        add_filler(len);
      end
    end

    // Closing: a VHDR whose length field bridges most of the gap, then the chunk that
    // reaches the form length, or an octave count that is too large.
    gap = longint'(form_len) - gen_total;
    case ($urandom_range(0, 3))
      0: begin
        len = $urandom_range(1, 5);
        add_vhdr(gap - len, 32'd1, 32'd0, 8'd1, $urandom);
        add_chunk_head(chunk_tag($urandom_range(1, 4)), len);
        add_filler(len);
      end
      1: begin
        // Overshoots the form length by one and ends on a byte with no event.
        len = $urandom_range(2, 6);
        add_vhdr(gap - len + 1, 32'd1, 32'd0, 8'd1, $urandom);
        add_chunk_head(chunk_tag($urandom_range(5, 7)), len);
        add_filler(len);
      end
      2: begin
        len = $urandom_range(1, 16'hFFFF);
        add_vhdr(gap - len, 32'd1, 32'd1, 8'd2, $urandom);
        add_body(len);
      end
      default: begin
        add_vhdr(32'd20, 32'd1, 32'd1,
                 8'($urandom_range(i8svx_pkg::MAX_OCTAVES + 1, 255)), $urandom);
        add_chunk_head(i8svx_pkg::TAG_BODY, $urandom);
      end
    endcase
    // After the terminal event these bytes must be dropped silently.
    add_filler(16);
    total_bytes = file_bytes.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    run_until(150);

    // Long receiver hold-off while the sender keeps offering.
    @(posedge clk);
    hold_go <= ~hold_go;
    @(posedge clk);
    while (hold_seen != hold_go || hold_left != 0) @(posedge clk);

    tx_idle_pct <= 57;
    run_until(450);

    // Sender pause until every outstanding event has drained.
    @(posedge clk);
    tx_pause <= 1'b1;
    @(posedge clk);
    while (in_ch.valid || events_seen != events_queued) @(posedge clk);
    tx_pause    <= 1'b0;
    tx_idle_pct <= 0;
    rx_stall_pct <= 57;
    run_until(800);

    tx_idle_pct  <= 13;
    rx_stall_pct <= 13;
    run_until(1100);

    mode = 0;
    while (bytes_accepted < total_bytes) begin
      case (mode)
        0: begin
          tx_idle_pct  <= 0;
          rx_stall_pct <= 0;
        end
        1: begin
          tx_idle_pct  <= 57;
          rx_stall_pct <= 0;
        end
        2: begin
          tx_idle_pct  <= 0;
          rx_stall_pct <= 57;
        end
        default: begin
          tx_idle_pct  <= 13;
          rx_stall_pct <= 13;
        end
      endcase
      mode = (mode + 1) % 4;
      @(posedge clk);
      run_until(bytes_accepted + 100);
    end

    while (events_seen != events_queued) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_events.size() != 0)
      report_mismatch($sformatf("%0d expected events never arrived", expected_events.size()));

    if (mismatch_cnt == 0) begin
      $display("tb_iff_8svx_chunk_parser_top OK");
    end else begin
      $display("tb_iff_8svx_chunk_parser_top NOT OK");
    end
    $finish;
  end

endmodule
